/* design/eqaa_pkg.sv */
// Package for the event queue arena allocator.
// Field widths, status and operation codes, controller states, result record.
// No dependencies.
`default_nettype none
package eqaa_pkg;

   localparam int ID_W      = 16;
   localparam int PRI_W     = 2;
   localparam int TIME_W    = 32;
   localparam int LEN_IN_W  = 16;
   localparam int STATUS_W  = 3;
   localparam int OFF_OUT_W = 12;
   localparam int LEN_OUT_W = 13;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_TOO_LARGE = 3'd1,
      ST_FULL      = 3'd2,
      ST_COLLIDE   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_POP,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type             status;
      logic [OFF_OUT_W-1:0]   arena_offset;
      logic [ID_W-1:0]        out_id;
      logic [PRI_W-1:0]       out_priority;
      logic [TIME_W-1:0]      out_time_ms;
      logic [LEN_OUT_W-1:0]   out_length;
   } result_type;

endpackage
`default_nettype wire

/* design/eqaa_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on eqaa_pkg for field widths.
`default_nettype none
interface eqaa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [eqaa_pkg::ID_W-1:0]     event_id;
   logic [eqaa_pkg::PRI_W-1:0]    event_priority;
   logic [eqaa_pkg::TIME_W-1:0]   event_time_ms;
   logic [eqaa_pkg::LEN_IN_W-1:0] payload_length;

   modport source (output valid, operation, event_id, event_priority, event_time_ms,
                   payload_length, input ready);
   modport sink   (input valid, operation, event_id, event_priority, event_time_ms,
                   payload_length, output ready);
endinterface

interface eqaa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [eqaa_pkg::STATUS_W-1:0]  status;
   logic [eqaa_pkg::OFF_OUT_W-1:0] arena_offset;
   logic [eqaa_pkg::ID_W-1:0]      out_id;
   logic [eqaa_pkg::PRI_W-1:0]     out_priority;
   logic [eqaa_pkg::TIME_W-1:0]    out_time_ms;
   logic [eqaa_pkg::LEN_OUT_W-1:0] out_length;

   modport source (output valid, status, arena_offset, out_id, out_priority, out_time_ms,
                   out_length, input ready);
   modport sink   (input valid, status, arena_offset, out_id, out_priority, out_time_ms,
                   out_length, output ready);
endinterface
`default_nettype wire

/* design/event_queue_arena_allocator_unit.sv */
// Top level of the event queue arena allocator: controller plus response register.
// Depends on eqaa_pkg, eqaa_if.sv and eqaa_ctrl.
//
//  channel   dir   modport  fields
//  req_if    in    sink     operation, event_id, event_priority, event_time_ms, payload_length
//  rsp_if    out   source   status, arena_offset, out_id, out_priority, out_time_ms, out_length
//
// Push: overlap scan over the N pending descriptors (at most QUEUE_DEPTH-1), one entry
// per cycle through the descriptor RAM read port, in S_SCAN.
// Pop: S_POP then S_DONE; rejected push or empty pop: straight to S_DONE.
// Synchronous reset empties the queue; descriptor RAM is not cleared.
// One transaction in flight; the next is taken while a result waits in the rsp register.
`default_nettype none
module event_queue_arena_allocator_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ARENA_BYTES = 4096
) (
   input  wire logic  clock,
   input  wire logic  reset,
   eqaa_req_if.sink   req_if,
   eqaa_rsp_if.source rsp_if
);

   logic                 res_valid, res_taken;
   eqaa_pkg::result_type res_data;
   eqaa_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   eqaa_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ARENA_BYTES (ARENA_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .res_valid (res_valid),
      .res_taken (res_taken),
      .res_data  (res_data)
   );

   assign res_taken    = res_valid && (!rsp_valid_ff || rsp_if.ready);
   assign rsp_valid_in = res_taken || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_in       = res_taken ? res_data : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_ff.status;
   assign rsp_if.arena_offset = rsp_ff.arena_offset;
   assign rsp_if.out_id       = rsp_ff.out_id;
   assign rsp_if.out_priority = rsp_ff.out_priority;
   assign rsp_if.out_time_ms  = rsp_ff.out_time_ms;
   assign rsp_if.out_length   = rsp_ff.out_length;

endmodule
`default_nettype wire

/* design/eqaa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module eqaa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/eqaa_ctrl.sv */
// Queue controller: ring pointers, fill offset, descriptor RAM and overlap scan.
// Depends on eqaa_pkg, eqaa_req_if and eqaa_ram.
`default_nettype none
module eqaa_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ARENA_BYTES = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   eqaa_req_if.sink                  req_if,
   output logic                      res_valid,
   input  wire logic                 res_taken,
   output eqaa_pkg::result_type      res_data
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int OFF_W  = $clog2(ARENA_BYTES);
   localparam int LEN_W  = $clog2(ARENA_BYTES + 1);
   localparam int SUM_W  = LEN_W + 1;
   localparam int CHK_W  = eqaa_pkg::LEN_IN_W + 2;
   localparam int SLOT_W = eqaa_pkg::ID_W + eqaa_pkg::PRI_W + eqaa_pkg::TIME_W + OFF_W + LEN_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [SUM_W-1:0] ARENA_SUM = SUM_W'(ARENA_BYTES);
   localparam logic [CHK_W-1:0] ARENA_CHK = CHK_W'(ARENA_BYTES);

   eqaa_pkg::state_type  state_ff, state_in;
   logic [PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in, scan_ff, scan_in;
   logic [OFF_W-1:0]     fill_ff, fill_in, start_ff, start_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 rd_pend_ff, rd_pend_in, collide_ff, collide_in;
   eqaa_pkg::op_type     op_ff, op_in;
   logic [eqaa_pkg::ID_W-1:0]   id_ff, id_in;
   logic [eqaa_pkg::PRI_W-1:0]  pri_ff, pri_in;
   logic [eqaa_pkg::TIME_W-1:0] time_ff, time_in;
   eqaa_pkg::result_type res_ff, res_in;

   logic [PTR_W-1:0]     wr_nxt, rd_nxt, scan_nxt;
   logic [LEN_W-1:0]     req_len;
   logic [SUM_W-1:0]     req_sum, new_end, ent_end;
   logic                 too_large, hit;

   logic                 ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0]     ram_rd_addr;
   logic [SLOT_W-1:0]    ram_wr_data, ram_rd_data;
   logic [OFF_W-1:0]     ent_off;
   logic [LEN_W-1:0]     ent_len;

   eqaa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign wr_nxt   = (wr_ff == LAST_SLOT) ? '0 : wr_ff + PTR_W'(1);
   assign rd_nxt   = (rd_ff == LAST_SLOT) ? '0 : rd_ff + PTR_W'(1);
   assign scan_nxt = (scan_ff == LAST_SLOT) ? '0 : scan_ff + PTR_W'(1);

   assign too_large = CHK_W'(req_if.payload_length) > ARENA_CHK;
   assign req_len   = LEN_W'(req_if.payload_length);
   assign req_sum   = SUM_W'(fill_ff) + SUM_W'(req_len);

   assign ent_len = ram_rd_data[LEN_W-1:0];
   assign ent_off = ram_rd_data[OFF_W+LEN_W-1:LEN_W];
   assign ent_end = SUM_W'(ent_off) + SUM_W'(ent_len);
   assign new_end = SUM_W'(start_ff) + SUM_W'(len_ff);
   assign hit     = (ent_len != '0) &&
                    !((new_end <= SUM_W'(ent_off)) || (SUM_W'(start_ff) >= ent_end));

   assign ram_wr_data = {id_ff, pri_ff, time_ff, start_ff, len_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= eqaa_pkg::S_IDLE;
         wr_ff      <= '0;
         rd_ff      <= '0;
         fill_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_ff      <= wr_in;
         rd_ff      <= rd_in;
         fill_ff    <= fill_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      start_ff   <= start_in;
      len_ff     <= len_in;
      collide_ff <= collide_in;
      op_ff      <= op_in;
      id_ff      <= id_in;
      pri_ff     <= pri_in;
      time_ff    <= time_in;
      res_ff     <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      fill_in     = fill_ff;
      scan_in     = scan_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      rd_pend_in  = 1'b0;
      collide_in  = collide_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      pri_in      = pri_ff;
      time_in     = time_ff;
      res_in      = res_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_ff;
      req_if.ready = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         eqaa_pkg::S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               res_in     = '0;
               op_in      = eqaa_pkg::op_type'(req_if.operation);
               id_in      = req_if.event_id;
               pri_in     = req_if.event_priority;
               time_in    = req_if.event_time_ms;
               len_in     = req_len;
               start_in   = (req_sum > ARENA_SUM) ? '0 : fill_ff;
               scan_in    = rd_ff;
               collide_in = 1'b0;
               if (req_if.operation == eqaa_pkg::OP_PUSH) begin
                  if (too_large) begin
                     res_in.status = eqaa_pkg::ST_TOO_LARGE;
                     state_in      = eqaa_pkg::S_DONE;
                  end else if (wr_nxt == rd_ff) begin
                     res_in.status = eqaa_pkg::ST_FULL;
                     state_in      = eqaa_pkg::S_DONE;
                  end else begin
                     state_in      = eqaa_pkg::S_SCAN;
                  end
               end else if (rd_ff == wr_ff) begin
                  res_in.status = eqaa_pkg::ST_EMPTY;
                  state_in      = eqaa_pkg::S_DONE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rd_ff;
                  state_in    = eqaa_pkg::S_POP;
               end
            end
         end
         eqaa_pkg::S_SCAN: begin
            collide_in = collide_ff | (rd_pend_ff & hit);
            if (scan_ff != wr_ff) begin
               ram_rd_en  = 1'b1;
               rd_pend_in = 1'b1;
               scan_in    = scan_nxt;
            end else begin
               if (collide_in) begin
                  res_in.status = eqaa_pkg::ST_COLLIDE;
               end else begin
                  res_in.status       = eqaa_pkg::ST_OK;
                  res_in.arena_offset = eqaa_pkg::OFF_OUT_W'(start_ff);
               end
               state_in = eqaa_pkg::S_DONE;
            end
         end
         eqaa_pkg::S_POP: begin
            res_in.status       = eqaa_pkg::ST_OK;
            res_in.arena_offset = eqaa_pkg::OFF_OUT_W'(ent_off);
            res_in.out_length   = eqaa_pkg::LEN_OUT_W'(ent_len);
            res_in.out_time_ms  = ram_rd_data[OFF_W+LEN_W+eqaa_pkg::TIME_W-1:OFF_W+LEN_W];
            res_in.out_priority = ram_rd_data[SLOT_W-eqaa_pkg::ID_W-1:
                                              SLOT_W-eqaa_pkg::ID_W-eqaa_pkg::PRI_W];
            res_in.out_id       = ram_rd_data[SLOT_W-1:SLOT_W-eqaa_pkg::ID_W];
            state_in            = eqaa_pkg::S_DONE;
         end
         eqaa_pkg::S_DONE: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = eqaa_pkg::S_IDLE;
               if (res_ff.status == eqaa_pkg::ST_OK) begin
                  if (op_ff == eqaa_pkg::OP_PUSH) begin
                     ram_wr_en = 1'b1;
                     wr_in     = wr_nxt;
                     fill_in   = (new_end == ARENA_SUM) ? '0 : OFF_W'(new_end);
                  end else begin
                     rd_in     = rd_nxt;
                  end
               end
            end
         end
         default: state_in = eqaa_pkg::S_IDLE;
      endcase
   end

   assign res_data = res_ff;

`ifndef SYNTH
   a_fill_in_arena: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(fill_ff) < ARENA_SUM)
      else $error("fill offset outside arena");

   a_no_read_in_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == eqaa_pkg::S_IDLE |-> !rd_pend_ff)
      else $error("scan read outstanding in idle");

   a_push_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == eqaa_pkg::S_DONE && res_taken && op_ff == eqaa_pkg::OP_PUSH &&
       res_ff.status == eqaa_pkg::ST_OK) |=> wr_ff != $past(wr_ff))
      else $error("accepted push did not advance write slot");

   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == eqaa_pkg::S_DONE && res_ff.status == eqaa_pkg::ST_EMPTY) |-> rd_ff == wr_ff)
      else $error("empty reported with entries pending");
`endif

endmodule
`default_nettype wire

/* tb/tb_event_queue_arena_allocator_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for event_queue_arena_allocator_unit: directed table, then random
// push/pop traffic with random stalls on both channels, checked against a behavioural model.
// Depends on eqaa_pkg, eqaa_if.sv and the unit under test.
module tb_event_queue_arena_allocator_unit;

   localparam int DEPTH        = 16;
   localparam int ARENA        = 4096;
   localparam int RANDOM_ITEMS = 950;
   localparam int LIMIT_CYCLES = 500000;
   localparam int TAIL_CYCLES  = 40;

   typedef struct {
      eqaa_pkg::op_type                  op;
      logic [eqaa_pkg::ID_W-1:0]         id;
      logic [eqaa_pkg::PRI_W-1:0]        pri;
      logic [eqaa_pkg::TIME_W-1:0]       stamp;
      logic [eqaa_pkg::LEN_IN_W-1:0]     len;
      bit                                typed;
      eqaa_pkg::result_type              want;
   } event_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   eqaa_req_if req_if();
   eqaa_rsp_if rsp_if();

   event_queue_arena_allocator_unit #(
      .QUEUE_DEPTH(DEPTH),
      .ARENA_BYTES(ARENA)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #4 clock = ~clock;

   // shadow copy of the descriptor ring and arena fill pointer
   logic [eqaa_pkg::ID_W-1:0]   ring_ids[DEPTH];
   logic [eqaa_pkg::PRI_W-1:0]  ring_pris[DEPTH];
   logic [eqaa_pkg::TIME_W-1:0] ring_stamps[DEPTH];
   int                          ring_offsets[DEPTH];
   int                          ring_lengths[DEPTH];
   int                          head_slot = 0;
   int                          tail_slot = 0;
   int                          fill_pos  = 0;

   eqaa_pkg::result_type        pending_results[$];
   event_request_type           directed_rows[$];
   int                          mismatch_count = 0;
   int                          cycle_count    = 0;
   bit                          steady_flow    = 1'b0;
   int                          ready_hold     = 0;

   function automatic eqaa_pkg::result_type step_event_queue(input event_request_type r);
      eqaa_pkg::result_type res;
      int                   start;
      int                   s;
      bit                   overlap;
      res = '0;
      res.status = eqaa_pkg::ST_OK;
      if (r.op == eqaa_pkg::OP_PUSH) begin
         if (int'(r.len) > ARENA) begin
            res.status = eqaa_pkg::ST_TOO_LARGE;
         end else if ((tail_slot + 1) % DEPTH == head_slot) begin
            res.status = eqaa_pkg::ST_FULL;
         end else begin
            start = fill_pos;
            if (start + int'(r.len) > ARENA) start = 0;
            overlap = 1'b0;
            s = head_slot;
            while (s != tail_slot) begin
               if (ring_lengths[s] > 0 &&
                   !(start + int'(r.len) <= ring_offsets[s] ||
                     start >= ring_offsets[s] + ring_lengths[s]))
                  overlap = 1'b1;
               s = (s + 1) % DEPTH;
            end
            if (overlap) begin
               res.status = eqaa_pkg::ST_COLLIDE;
            end else begin
               ring_ids[tail_slot]     = r.id;
               ring_pris[tail_slot]    = r.pri;
               ring_stamps[tail_slot]  = r.stamp;
               ring_offsets[tail_slot] = start;
               ring_lengths[tail_slot] = int'(r.len);
               tail_slot = (tail_slot + 1) % DEPTH;
               fill_pos = (start + int'(r.len)) % ARENA;
               res.arena_offset = start[eqaa_pkg::OFF_OUT_W-1:0];
            end
         end
      end else begin
         if (head_slot == tail_slot) begin
            res.status = eqaa_pkg::ST_EMPTY;
         end else begin
            res.arena_offset = ring_offsets[head_slot][eqaa_pkg::OFF_OUT_W-1:0];
            res.out_id       = ring_ids[head_slot];
            res.out_priority = ring_pris[head_slot];
            res.out_time_ms  = ring_stamps[head_slot];
            res.out_length   = ring_lengths[head_slot][eqaa_pkg::LEN_OUT_W-1:0];
            head_slot = (head_slot + 1) % DEPTH;
         end
      end
      return res;
   endfunction

   function automatic event_request_type table_row(
      input eqaa_pkg::op_type op, input logic [eqaa_pkg::ID_W-1:0] id,
      input logic [eqaa_pkg::PRI_W-1:0] pri, input logic [eqaa_pkg::TIME_W-1:0] stamp,
      input logic [eqaa_pkg::LEN_IN_W-1:0] len, input bit typed,
      input eqaa_pkg::status_type st, input logic [eqaa_pkg::OFF_OUT_W-1:0] off,
      input logic [eqaa_pkg::ID_W-1:0] oid, input logic [eqaa_pkg::PRI_W-1:0] opri,
      input logic [eqaa_pkg::TIME_W-1:0] otime,
      input logic [eqaa_pkg::LEN_OUT_W-1:0] olen);
      event_request_type r;
      r.op    = op;
      r.id    = id;
      r.pri   = pri;
      r.stamp = stamp;
      r.len   = len;
      r.typed = typed;
      r.want.status       = st;
      r.want.arena_offset = off;
      r.want.out_id       = oid;
      r.want.out_priority = opri;
      r.want.out_time_ms  = otime;
      r.want.out_length   = olen;
      return r;
   endfunction

   function automatic event_request_type random_request(input int push_bias);
      event_request_type r;
      int                pick;
      r = table_row(eqaa_pkg::OP_PUSH, 16'($urandom), 2'($urandom), $urandom, '0, 1'b0,
                    eqaa_pkg::ST_OK, '0, '0, '0, '0, '0);
      if ($urandom_range(0, 99) >= push_bias) r.op = eqaa_pkg::OP_POP;
      pick = $urandom_range(0, 99);
      if (pick < 10)      r.len = '0;
      else if (pick < 70) r.len = 16'($urandom_range(1, 500));
      else if (pick < 88) r.len = 16'($urandom_range(501, ARENA));
      else if (pick < 92) r.len = 16'(ARENA);
      else                r.len = 16'($urandom);
      return r;
   endfunction

   task automatic offer_request(input event_request_type r);
      eqaa_pkg::result_type answer;
      req_if.valid          <= 1'b1;
      req_if.operation      <= r.op;
      req_if.event_id       <= r.id;
      req_if.event_priority <= r.pri;
      req_if.event_time_ms  <= r.stamp;
      req_if.payload_length <= r.len;
      do @(posedge clock); while (!req_if.ready);
      answer = step_event_queue(r);
      pending_results.push_back(r.typed ? r.want : answer);
   endtask

   task automatic idle_sender();
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (steady_flow || pick < 65) gap = 0;
      else if (pick < 92)           gap = $urandom_range(1, 3);
      else                          gap = $urandom_range(8, 40);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : response_check
      eqaa_pkg::result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $error("response transaction with none outstanding: status %0d",
                   rsp_if.status);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status",       32'(want.status),       32'(rsp_if.status));
            check_field("arena_offset", 32'(want.arena_offset), 32'(rsp_if.arena_offset));
            check_field("out_id",       32'(want.out_id),       32'(rsp_if.out_id));
            check_field("out_priority", 32'(want.out_priority), 32'(rsp_if.out_priority));
            check_field("out_time_ms",  want.out_time_ms,       rsp_if.out_time_ms);
            check_field("out_length",   32'(want.out_length),   32'(rsp_if.out_length));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         ready_hold   <= 0;
      end else if (steady_flow) begin
         rsp_if.ready <= 1'b1;
         ready_hold   <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 3) != 0);
         ready_hold   <= ($urandom_range(0, 9) != 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(15, 60);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int n;
      int push_bias;
      req_if.valid          <= 1'b0;
      req_if.operation      <= eqaa_pkg::OP_PUSH;
      req_if.event_id       <= '0;
      req_if.event_priority <= '0;
      req_if.event_time_ms  <= '0;
      req_if.payload_length <= '0;
      push_bias = 60;

      // empty pop, oversize, whole-arena region, collision, zero-length entries
      directed_rows.push_back(table_row(eqaa_pkg::OP_POP, 16'h1234, 2'd2, 32'h5, 16'd7, 1'b1,
                              eqaa_pkg::ST_EMPTY, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h0001, 2'd1, 32'h1, 16'hFFFF,
                              1'b1, eqaa_pkg::ST_TOO_LARGE, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h0002, 2'd1, 32'h2, 16'd4097,
                              1'b1, eqaa_pkg::ST_TOO_LARGE, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'hFFFF, 2'd3, 32'hFFFF_FFFF,
                              16'd4096, 1'b1, eqaa_pkg::ST_OK, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h0003, 2'd0, 32'h3, 16'd1,
                              1'b1, eqaa_pkg::ST_COLLIDE, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h8000, 2'd1, 32'h8000_0001,
                              16'd0, 1'b1, eqaa_pkg::ST_OK, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_POP, '0, '0, '0, '0, 1'b1,
                              eqaa_pkg::ST_OK, '0, 16'hFFFF, 2'd3, 32'hFFFF_FFFF,
                              13'd4096));
      directed_rows.push_back(table_row(eqaa_pkg::OP_POP, '0, '0, '0, '0, 1'b1,
                              eqaa_pkg::ST_OK, '0, 16'h8000, 2'd1, 32'h8000_0001, 13'd0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_POP, '0, '0, '0, '0, 1'b1,
                              eqaa_pkg::ST_EMPTY, '0, '0, '0, '0, '0));
      // region up to the arena end, then a request wrapped back onto a live region
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h00A5, 2'd2, 32'h0000_0100,
                              16'd100, 1'b0, eqaa_pkg::ST_OK, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h5A00, 2'd1, 32'h7FFF_FFFF,
                              16'd3996, 1'b0, eqaa_pkg::ST_OK, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h0004, 2'd0, 32'h4, 16'd1,
                              1'b1, eqaa_pkg::ST_COLLIDE, '0, '0, '0, '0, '0));
      // fill the ring with zero-length entries
      for (n = 0; n < DEPTH - 3; n++)
         directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'(16'h1111 * n), 2'(n),
                                 32'(n << 20), 16'd0, 1'b0, eqaa_pkg::ST_OK,
                                 '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h0005, 2'd3, 32'h5, 16'd4096,
                              1'b1, eqaa_pkg::ST_FULL, '0, '0, '0, '0, '0));
      directed_rows.push_back(table_row(eqaa_pkg::OP_PUSH, 16'h0006, 2'd3, 32'h6, 16'd5000,
                              1'b1, eqaa_pkg::ST_TOO_LARGE, '0, '0, '0, '0, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_request(directed_rows[i]);
         idle_sender();
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            push_bias = ($urandom_range(0, 1) != 0) ? $urandom_range(65, 85)
                                                    : $urandom_range(20, 40);
            steady_flow <= ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2) begin
            // hold off until the unit has drained
            req_if.valid <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
         end
         offer_request(random_request(push_bias));
         idle_sender();
      end

      req_if.valid <= 1'b0;
      steady_flow  <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
design/eqaa_pkg.sv
design/eqaa_if.sv
design/eqaa_ram.sv
design/eqaa_ctrl.sv
design/event_queue_arena_allocator_unit.sv
tb/tb_event_queue_arena_allocator_unit.sv
